[design/periodic_task_scheduler_macros.svh]
// Assertion macros for the periodic task scheduler.
`ifndef PERIODIC_TASK_SCHEDULER_MACROS_SVH
`define PERIODIC_TASK_SCHEDULER_MACROS_SVH

`ifndef NO_ASSERTIONS

`define PTS_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) prop) else $error(msg);

`define PTS_ASSERT_ALWAYS(lbl, prop, msg) \
    lbl: assert property (@(posedge i_clk) prop) else $error(msg);

`else

`define PTS_ASSERT(lbl, prop, msg)

`define PTS_ASSERT_ALWAYS(lbl, prop, msg)

`endif

`endif

[design/pts_pkg.sv]
`default_nettype none

package pts_pkg;

    localparam int TIME_W      = 32;
    localparam int INDEX_W     = 4;
    localparam int HELD_W      = 5;
    localparam int IN_TDATA_W  = 104;
    localparam int OUT_TDATA_W = 16;

    localparam logic CMD_REGISTER = 1'b0;
    localparam logic CMD_TICK     = 1'b1;

    typedef enum logic [1:0] {
        KIND_REGISTERED = 2'd0,
        KIND_REJECTED   = 2'd1,
        KIND_DUE        = 2'd2,
        KIND_TICK_DONE  = 2'd3
    } t_kind;

    typedef struct packed {
        logic              enabled;
        logic              handler;
        logic [TIME_W-1:0] period;
        logic [TIME_W-1:0] due;
    } t_entry;

endpackage

`default_nettype wire

[design/periodic_task_scheduler.sv]
// Periodic task scheduler. Tasks are appended to a table of TASK_SLOTS entries held in one
// synchronous memory (one write port, one read port, registered read). A register transaction
// is captured, then the table write (none when the table is full) and its single result.
// A tick transaction walks the N held tasks, reading one table entry per cycle while not held
// through the memory read port; each due entry has its next due time written back in the
// same cycle that the following entry is read. A due result that cannot leave because the
// output register is still full holds the walk in place. Table entries are not cleared
// after reset; only entries below the task count are ever read, so the block is ready at once.
`default_nettype none
`include "periodic_task_scheduler_macros.svh"

module periodic_task_scheduler
    import pts_pkg::*;
#(
    parameter int TASK_SLOTS = 16
) (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   s_axis_tvalid,
    output logic                   s_axis_tready,
    // tdata: task_enabled, handler_present, interval_ms, first_due_ms, now_ms, zero fill
    input  logic [IN_TDATA_W-1:0]  s_axis_tdata,
    // tuser: command
    input  logic [0:0]             s_axis_tuser,
    output logic                   m_axis_tvalid,
    input  logic                   m_axis_tready,
    // tdata: task_index, tasks_held, zero fill
    output logic [OUT_TDATA_W-1:0] m_axis_tdata,
    // tuser: result_kind
    output logic [1:0]             m_axis_tuser,
    output logic                   m_axis_tlast
);

    localparam int IW = (TASK_SLOTS > 1) ? $clog2(TASK_SLOTS) : 1;
    localparam int CW = $clog2(TASK_SLOTS + 1);

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_REG,
        ST_EVAL,
        ST_DONE
    } t_state;

    t_state            r_state, n_state;
    logic [CW-1:0]     r_total, n_total;
    logic [IW-1:0]     r_idx, n_idx;
    logic              r_m_valid, n_m_valid;
    t_kind             r_kind, n_kind;
    logic [INDEX_W-1:0] r_out_index, n_out_index;
    logic [HELD_W-1:0] r_out_held, n_out_held;
    logic              r_out_last, n_out_last;

    logic              r_cmd_en;
    logic              r_cmd_hdl;
    logic [TIME_W-1:0] r_cmd_period;
    logic [TIME_W-1:0] r_cmd_first;
    logic [TIME_W-1:0] r_now;

    t_entry            r_task_mem [TASK_SLOTS];
    t_entry            r_rd_data;
    logic              rd_en;
    logic [IW-1:0]     rd_addr;
    logic              wr_en;
    logic [IW-1:0]     wr_addr;
    t_entry            wr_data;

    logic              s_accept;
    logic              out_free;
    logic              due_hit;
    logic [CW-1:0]     next_idx;

    assign s_axis_tready = (r_state == ST_IDLE);
    assign s_accept      = s_axis_tvalid && s_axis_tready;
    assign out_free      = !r_m_valid || m_axis_tready;
    assign due_hit       = r_rd_data.enabled && r_rd_data.handler && (r_rd_data.due <= r_now);
    assign next_idx      = CW'(r_idx) + CW'(1);

    assign m_axis_tvalid = r_m_valid;
    assign m_axis_tuser  = r_kind;
    assign m_axis_tlast  = r_out_last;
    assign m_axis_tdata  = {{(OUT_TDATA_W - HELD_W - INDEX_W){1'b0}}, r_out_held, r_out_index};

    always_comb begin
        n_state     = r_state;
        n_total     = r_total;
        n_idx       = r_idx;
        n_m_valid   = r_m_valid && !m_axis_tready;
        n_kind      = r_kind;
        n_out_index = r_out_index;
        n_out_held  = r_out_held;
        n_out_last  = r_out_last;
        rd_en       = 1'b0;
        rd_addr     = r_idx;
        wr_en       = 1'b0;
        wr_addr     = r_idx;
        wr_data     = r_rd_data;

        case (r_state)
            ST_IDLE: begin
                if (s_accept) begin
                    if (s_axis_tuser[0] == CMD_TICK) begin
                        if (r_total == '0) begin
                            n_state = ST_DONE;
                        end else begin
                            rd_en   = 1'b1;
                            rd_addr = '0;
                            n_idx   = '0;
                            n_state = ST_EVAL;
                        end
                    end else begin
                        n_state = ST_REG;
                    end
                end
            end
            ST_REG: begin
                if (out_free) begin
                    n_m_valid  = 1'b1;
                    n_out_last = 1'b1;
                    if (r_total == CW'(TASK_SLOTS)) begin
                        n_kind      = KIND_REJECTED;
                        n_out_index = '0;
                        n_out_held  = HELD_W'(r_total);
                    end else begin
                        wr_en          = 1'b1;
                        wr_addr        = IW'(r_total);
                        wr_data.enabled = r_cmd_en;
                        wr_data.handler = r_cmd_hdl;
                        wr_data.period  = r_cmd_period;
                        wr_data.due     = r_cmd_first;
                        n_total     = r_total + CW'(1);
                        n_kind      = KIND_REGISTERED;
                        n_out_index = INDEX_W'(r_total);
                        n_out_held  = HELD_W'(r_total + CW'(1));
                    end
                    n_state = ST_IDLE;
                end
            end
            ST_EVAL: begin
                if (!due_hit || out_free) begin
                    if (due_hit) begin
                        n_m_valid   = 1'b1;
                        n_kind      = KIND_DUE;
                        n_out_index = INDEX_W'(r_idx);
                        n_out_held  = HELD_W'(r_total);
                        n_out_last  = 1'b0;
                        wr_en       = 1'b1;
                        wr_addr     = r_idx;
                        wr_data.due = r_now + r_rd_data.period;
                    end
                    if (next_idx < r_total) begin
                        rd_en   = 1'b1;
                        rd_addr = r_idx + IW'(1);
                        n_idx   = r_idx + IW'(1);
                    end else begin
                        n_state = ST_DONE;
                    end
                end
            end
            ST_DONE: begin
                if (out_free) begin
                    n_m_valid   = 1'b1;
                    n_kind      = KIND_TICK_DONE;
                    n_out_index = '0;
                    n_out_held  = HELD_W'(r_total);
                    n_out_last  = 1'b1;
                    n_state     = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= ST_IDLE;
            r_total   <= '0;
            r_idx     <= '0;
            r_m_valid <= 1'b0;
        end else begin
            r_state   <= n_state;
            r_total   <= n_total;
            r_idx     <= n_idx;
            r_m_valid <= n_m_valid;
        end
        r_kind      <= n_kind;
        r_out_index <= n_out_index;
        r_out_held  <= n_out_held;
        r_out_last  <= n_out_last;
        if (s_accept) begin
            r_cmd_en     <= s_axis_tdata[0];
            r_cmd_hdl    <= s_axis_tdata[1];
            r_cmd_period <= s_axis_tdata[33:2];
            r_cmd_first  <= s_axis_tdata[65:34];
            r_now        <= s_axis_tdata[97:66];
        end
    end

    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            r_task_mem[wr_addr] <= wr_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (rd_en) begin
            r_rd_data <= r_task_mem[rd_addr];
        end
    end

    `PTS_ASSERT(a_total_bound, r_total <= CW'(TASK_SLOTS), "Task count exceeds the table size.")
    `PTS_ASSERT(a_walk_in_range, (r_state != ST_EVAL) || (CW'(r_idx) < r_total),
                "Tick walk reads beyond the filled entries.")
    `PTS_ASSERT(a_total_step, (!$stable(r_total) && $past(i_rst_n)) |->
                (r_total == $past(r_total) + CW'(1)), "Task count changed by other than one.")
    `PTS_ASSERT(a_last_marks, m_axis_tvalid |-> ((m_axis_tuser == KIND_DUE) != m_axis_tlast),
                "Only a due result may leave without the last flag.")
    `PTS_ASSERT_ALWAYS(a_write_read_apart, (wr_en && rd_en) |-> (wr_addr != rd_addr),
                "Table write and read hit the same entry in one cycle.")

endmodule

`default_nettype wire

[bench/periodic_task_scheduler_checker.sv]
`timescale 1ns / 100ps

module periodic_task_scheduler_checker
    import pts_pkg::*;
#(
    parameter int TASK_SLOTS = 16
) (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_in_valid,
    input  logic                   i_in_ready,
    // tdata: task_enabled, handler_present, interval_ms, first_due_ms, now_ms, zero fill
    input  logic [IN_TDATA_W-1:0]  i_in_data,
    // tuser: command
    input  logic [0:0]             i_in_user,
    input  logic                   i_out_valid,
    input  logic                   i_out_ready,
    // tdata: task_index, tasks_held, zero fill
    input  logic [OUT_TDATA_W-1:0] i_out_data,
    // tuser: result_kind
    input  logic [1:0]             i_out_kind,
    input  logic                   i_out_last,
    output int                     o_fail_count,
    output int                     o_pending
);

    localparam int ENABLED_BIT = 0;
    localparam int HANDLER_BIT = 1;
    localparam int PERIOD_LO   = 2;
    localparam int DUE_LO      = PERIOD_LO + TIME_W;
    localparam int NOW_LO      = DUE_LO + TIME_W;

    typedef struct packed {
        t_kind              kind;
        logic [INDEX_W-1:0] index;
        logic [HELD_W-1:0]  held;
        logic               last;
    } t_result;

    t_entry            task_table [TASK_SLOTS];
    logic [HELD_W-1:0] tasks_registered;
    t_result           awaited_results [$];
    int                failures;
    t_result           seen;
    t_result           wanted;

    function automatic void post_result(t_kind kind, int index, logic last);
        awaited_results.push_back('{kind: kind, index: INDEX_W'(index),
                                    held: tasks_registered, last: last});
    endfunction

    function automatic void advance_schedule(logic cmd, logic [IN_TDATA_W-1:0] data);
        logic [TIME_W-1:0] now;
        now = data[NOW_LO +: TIME_W];
        if (cmd == CMD_REGISTER) begin
            if (tasks_registered >= TASK_SLOTS) begin
                post_result(KIND_REJECTED, 0, 1'b1);
            end else begin
                task_table[tasks_registered] = '{enabled: data[ENABLED_BIT],
                                                 handler: data[HANDLER_BIT],
                                                 period:  data[PERIOD_LO +: TIME_W],
                                                 due:     data[DUE_LO +: TIME_W]};
                tasks_registered = tasks_registered + 1'b1;
                post_result(KIND_REGISTERED, tasks_registered - 1, 1'b1);
            end
        end else begin
            for (int i = 0; i < tasks_registered; i++) begin
                if (task_table[i].enabled && task_table[i].handler &&
                        task_table[i].due <= now) begin
                    post_result(KIND_DUE, i, 1'b0);
                    task_table[i].due = now + task_table[i].period;
                end
            end
            post_result(KIND_TICK_DONE, 0, 1'b1);
        end
    endfunction

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            tasks_registered = '0;
            awaited_results.delete();
            failures = 0;
            o_pending <= 0;
            o_fail_count <= 0;
        end else begin
            if (i_out_valid && i_out_ready) begin
                seen = '{kind: t_kind'(i_out_kind), index: i_out_data[INDEX_W-1:0],
                         held: i_out_data[INDEX_W +: HELD_W], last: i_out_last};
                if (awaited_results.size() == 0) begin
                    failures++;
                    if (failures <= 10) begin
                        $display("%0t: unexpected result kind %0d index %0d held %0d last %0d",
                                 $time, seen.kind, seen.index, seen.held, seen.last);
                    end
                end else begin
                    wanted = awaited_results.pop_front();
                    if (seen !== wanted) begin
                        failures++;
                        if (failures <= 10) begin
                            $write("%0t: result mismatch, ", $time);
                            $write("expected kind %0d index %0d held %0d last %0d, ",
                                   wanted.kind, wanted.index, wanted.held, wanted.last);
                            $display("got kind %0d index %0d held %0d last %0d",
                                     seen.kind, seen.index, seen.held, seen.last);
                        end
                    end
                end
            end
            if (i_in_valid && i_in_ready) begin
                advance_schedule(i_in_user[0], i_in_data);
            end
            o_pending <= awaited_results.size();
            o_fail_count <= failures;
        end
    end

endmodule

[bench/testbench.sv]
`timescale 1ns / 100ps

module testbench;
    import pts_pkg::*;

    localparam int STALL_LIMIT = 2000;

    logic                   i_clk = 1'b0;
    logic                   i_rst_n;
    logic                   s_axis_tvalid;
    logic                   s_axis_tready;
    logic [IN_TDATA_W-1:0]  s_axis_tdata;
    logic [0:0]             s_axis_tuser;
    logic                   m_axis_tvalid;
    logic                   m_axis_tready;
    logic [OUT_TDATA_W-1:0] m_axis_tdata;
    logic [1:0]             m_axis_tuser;
    logic                   m_axis_tlast;

    int                     fail_count;
    int                     pending;
    int                     idle_cycles;
    bit                     sender_burst;
    bit                     receiver_burst;
    int                     results_taken;
    logic [TIME_W-1:0]      clock_ms;
    logic [TIME_W-1:0]      period;
    logic [TIME_W-1:0]      first_due;

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    periodic_task_scheduler i_dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .m_axis_tlast  (m_axis_tlast)
    );

    periodic_task_scheduler_checker i_checker (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_in_valid   (s_axis_tvalid),
        .i_in_ready   (s_axis_tready),
        .i_in_data    (s_axis_tdata),
        .i_in_user    (s_axis_tuser),
        .i_out_valid  (m_axis_tvalid),
        .i_out_ready  (m_axis_tready),
        .i_out_data   (m_axis_tdata),
        .i_out_kind   (m_axis_tuser),
        .i_out_last   (m_axis_tlast),
        .o_fail_count (fail_count),
        .o_pending    (pending)
    );

    always @(posedge i_clk) begin
        if (!i_rst_n || (s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) begin
            idle_cycles <= 0;
        end else if (idle_cycles >= STALL_LIMIT) begin
            $display("[periodic_task_scheduler] ERROR");
            $finish;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    initial begin
        int gap;
        m_axis_tready <= 1'b0;
        receiver_burst = 1'b0;
        results_taken = 0;
        do @(posedge i_clk); while (!i_rst_n);
        forever begin
            if (results_taken % 40 == 0) begin
                receiver_burst = ($urandom_range(0, 3) == 0);
            end
            gap = receiver_burst ? 0 : $urandom_range(0, 19);
            if (gap > 0) begin
                m_axis_tready <= 1'b0;
                repeat (gap) @(posedge i_clk);
            end
            m_axis_tready <= 1'b1;
            do @(posedge i_clk); while (!m_axis_tvalid);
            results_taken++;
        end
    end

    task automatic send_item(input logic cmd, input logic [IN_TDATA_W-1:0] data);
        int gap;
        gap = sender_burst ? 0 : $urandom_range(0, 19);
        if (gap > 0) begin
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tuser <= cmd;
        s_axis_tdata <= data;
        do @(posedge i_clk); while (!s_axis_tready);
    endtask

    task automatic register_task(input logic enabled, input logic handler,
                                 input logic [TIME_W-1:0] every, input logic [TIME_W-1:0] due);
        send_item(CMD_REGISTER, {6'b0, 32'($urandom()), due, every, handler, enabled});
    endtask

    task automatic tick(input logic [TIME_W-1:0] now);
        send_item(CMD_TICK, {6'b0, now, 32'($urandom()), 32'($urandom()), 2'($urandom())});
    endtask

    initial begin
        i_rst_n <= 1'b0;
        s_axis_tvalid <= 1'b0;
        s_axis_tdata <= '0;
        s_axis_tuser <= CMD_REGISTER;
        sender_burst = 1'b0;
        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;

        tick(32'd0);
        tick(32'hFFFF_FFFF);
        register_task(1'b1, 1'b1, 32'd0, 32'd0);
        register_task(1'b0, 1'b1, 32'd5, 32'd0);
        register_task(1'b1, 1'b0, 32'd7, 32'd0);
        register_task(1'b0, 1'b0, 32'd1, 32'd0);
        register_task(1'b1, 1'b1, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
        register_task(1'b1, 1'b1, 32'd10, 32'd100);
        tick(32'd0);
        tick(32'd100);
        tick(32'hFFFF_FFFF);
        tick(32'd5);
        tick(32'd9);
        clock_ms = 32'd9;

        for (int k = 0; k < 420; k++) begin
            if (k % 30 == 0) begin
                sender_burst = ($urandom_range(0, 3) == 0);
            end
            if ($urandom_range(0, 99) < 12) begin
                case ($urandom_range(0, 9))
                    7:       period = 32'd0;
                    8:       period = 32'hFFFF_FFFF;
                    9:       period = $urandom();
                    default: period = $urandom_range(0, 40);
                endcase
                case ($urandom_range(0, 9))
                    7:       first_due = $urandom();
                    8:       first_due = 32'd0;
                    9:       first_due = 32'hFFFF_FFFF;
                    default: first_due = clock_ms + $urandom_range(0, 60);
                endcase
                register_task($urandom_range(0, 3) != 0, $urandom_range(0, 3) != 0,
                              period, first_due);
            end else begin
                case ($urandom_range(0, 9))
                    8:       clock_ms = $urandom();
                    9:       clock_ms = 32'hFFFF_FFFF - $urandom_range(0, 30);
                    default: clock_ms = clock_ms + $urandom_range(0, 25);
                endcase
                tick(clock_ms);
            end
        end
        s_axis_tvalid <= 1'b0;

        do @(posedge i_clk); while (pending != 0);
        repeat (40) @(posedge i_clk);
        if (fail_count == 0 && pending == 0) begin
            $display("[periodic_task_scheduler] OK");
        end else begin
            $display("[periodic_task_scheduler] ERROR");
        end
        $finish;
    end

endmodule
